// ===== sv/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants of the MIDI track event parser: parse phases,
// event kind codes, status byte codes and the result record.
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam int unsigned DATA_W       = 8;
   localparam int unsigned DELTA_W      = 28;
   localparam int unsigned KIND_W       = 3;
   localparam int unsigned CHAN_W       = 4;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam int unsigned DCNT_W       = 3;
   localparam int unsigned REM_W        = 8;

   // longest delta time accepted, in bytes
   localparam logic [DCNT_W-1:0] MAX_DELTA_BYTES = 3'd4;

   // register indexes (byte address bits [CSR_ADDR_W-1:2])
   localparam logic REG_CHANNEL_NUMBER = 1'b0;

   // event kinds
   localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PATCH    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NAME     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_END      = 3'd4;
   localparam logic [KIND_W-1:0] KIND_TEMPO    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_TIMESIG  = 3'd6;
   localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd7;

   // status and meta type bytes
   localparam logic [DATA_W-1:0] STATUS_META     = 8'hFF;
   localparam logic [DATA_W-1:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [DATA_W-1:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [DATA_W-1:0] STATUS_PATCH    = 8'hC0;
   localparam logic [DATA_W-1:0] META_NAME       = 8'h03;
   localparam logic [DATA_W-1:0] META_END        = 8'h2F;
   localparam logic [DATA_W-1:0] META_TEMPO      = 8'h51;
   localparam logic [DATA_W-1:0] META_TIMESIG    = 8'h58;

   // data bytes still to come after the type byte
   localparam logic [REM_W-1:0] REM_NOTE    = 8'd2;
   localparam logic [REM_W-1:0] REM_PATCH   = 8'd1;
   localparam logic [REM_W-1:0] REM_END     = 8'd1;
   localparam logic [REM_W-1:0] REM_TEMPO   = 8'd4;
   localparam logic [REM_W-1:0] REM_TIMESIG = 8'd5;

   typedef enum logic [4:0] {
      PH_DELTA    = 5'b00001,
      PH_STATUS   = 5'b00010,
      PH_METATYPE = 5'b00100,
      PH_METALEN  = 5'b01000,
      PH_BODY     = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [DATA_W-1:0]  event_byte;
      logic [DELTA_W-1:0] delta_time;
      logic [KIND_W-1:0]  event_kind;
      logic               first_of_event;
      logic               last_of_event;
   } result_type;

   typedef struct packed {
      logic      halted;
      phase_type phase;
   } status_type;

endpackage

// ===== sv/mtep_if.sv =====
// ----------------------------------------------------------------------------
// mtep_if
// Valid/ready channels of the parser: raw track bytes in, event bytes out.
// ----------------------------------------------------------------------------
interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface mtep_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  event_byte;
   logic [27:0] delta_time;
   logic [2:0]  event_kind;
   logic        first_of_event;
   logic        last_of_event;

   modport source (output valid, output event_byte, output delta_time, output event_kind,
                   output first_of_event, output last_of_event, input ready);
   modport sink   (input valid, input event_byte, input delta_time, input event_kind,
                   input first_of_event, input last_of_event, output ready);
endinterface

// ===== sv/mtep_csr.sv =====
// ----------------------------------------------------------------------------
// mtep_csr
// APB-style register port holding the channel number.
// ----------------------------------------------------------------------------
module mtep_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mtep_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mtep_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mtep_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output logic [mtep_pkg::CHAN_W-1:0]        channel_number
);
   import mtep_pkg::*;

   logic [CHAN_W-1:0] chan_ff;
   logic [CHAN_W-1:0] chan_in;
   logic              hit;

   assign pready = 1'b1;
   assign hit    = (paddr[CSR_ADDR_W-1] == REG_CHANNEL_NUMBER);

   always_comb begin
      chan_in = chan_ff;
      if (psel && penable && pwrite && pready && hit) begin
         chan_in = pwdata[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= '0;
      end else begin
         chan_ff <= chan_in;
      end
   end

   assign prdata         = hit ? {{(CSR_DATA_W-CHAN_W){1'b0}}, chan_ff} : '0;
   assign channel_number = chan_ff;

endmodule

// ===== sv/mtep_parser.sv =====
// ----------------------------------------------------------------------------
// mtep_parser
// Parse state and per-byte decode: delta time collection, event
// classification and tagging of each forwarded byte.
// ----------------------------------------------------------------------------
module mtep_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [mtep_pkg::DATA_W-1:0]   data_byte,
   input  logic [mtep_pkg::CHAN_W-1:0]   channel_number,
   output logic                          res_valid,
   output mtep_pkg::result_type          res,
   output mtep_pkg::status_type          status
);
   import mtep_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [DELTA_W-1:0] delta_ff, delta_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic               halted_ff, halted_in;
   logic [REM_W-1:0]   rem_dec;
   logic               fail;
   logic               done;

   assign rem_dec = (rem_ff != '0) ? rem_ff - REM_W'(1) : rem_ff;

   always_comb begin
      phase_in  = phase_ff;
      delta_in  = delta_ff;
      dcnt_in   = dcnt_ff;
      rem_in    = rem_ff;
      kind_in   = kind_ff;
      halted_in = halted_ff;
      fail      = 1'b0;
      done      = 1'b0;
      res_valid = 1'b0;
      res.event_byte     = data_byte;
      res.delta_time     = delta_ff;
      res.event_kind     = kind_ff;
      res.first_of_event = 1'b0;
      res.last_of_event  = 1'b0;

      if (!halted_ff) begin
         case (phase_ff)
            PH_DELTA: begin
               if (dcnt_ff >= MAX_DELTA_BYTES) begin
                  fail = 1'b1;
               end else begin
                  delta_in = {delta_ff[DELTA_W-8:0], data_byte[6:0]};
                  dcnt_in  = dcnt_ff + DCNT_W'(1);
                  if (!data_byte[7]) begin
                     phase_in = PH_STATUS;
                  end
               end
            end
            PH_STATUS: begin
               res.first_of_event = 1'b1;
               res_valid          = 1'b1;
               if (data_byte == STATUS_META) begin
                  res.event_kind = KIND_NOTE_OFF;
                  phase_in       = PH_METATYPE;
               end else if (data_byte == STATUS_NOTE_OFF || data_byte == STATUS_NOTE_ON) begin
                  kind_in        = (data_byte == STATUS_NOTE_OFF) ? KIND_NOTE_OFF : KIND_NOTE_ON;
                  res.event_kind = kind_in;
                  res.event_byte = data_byte | {{(DATA_W-CHAN_W){1'b0}}, channel_number};
                  rem_in         = REM_NOTE;
                  phase_in       = PH_BODY;
               end else if (data_byte == STATUS_PATCH) begin
                  kind_in        = KIND_PATCH;
                  res.event_kind = KIND_PATCH;
                  res.event_byte = data_byte | {{(DATA_W-CHAN_W){1'b0}}, channel_number};
                  rem_in         = REM_PATCH;
                  phase_in       = PH_BODY;
               end else begin
                  fail = 1'b1;
               end
            end
            PH_METATYPE: begin
               res_valid = 1'b1;
               phase_in  = PH_BODY;
               case (data_byte)
                  META_NAME: begin
                     kind_in  = KIND_NAME;
                     phase_in = PH_METALEN;
                  end
                  META_END: begin
                     kind_in = KIND_END;
                     rem_in  = REM_END;
                  end
                  META_TEMPO: begin
                     kind_in = KIND_TEMPO;
                     rem_in  = REM_TEMPO;
                  end
                  META_TIMESIG: begin
                     kind_in = KIND_TIMESIG;
                     rem_in  = REM_TIMESIG;
                  end
                  default: begin
                     fail     = 1'b1;
                     phase_in = phase_ff;
                  end
               endcase
               res.event_kind = kind_in;
            end
            PH_METALEN: begin
               res_valid         = 1'b1;
               res.last_of_event = (data_byte == '0);
               if (data_byte == '0) begin
                  done = 1'b1;
               end else begin
                  rem_in   = data_byte[REM_W-1:0];
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               res_valid         = 1'b1;
               rem_in            = rem_dec;
               res.last_of_event = (rem_dec == '0);
               done              = (rem_dec == '0);
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase

         // error: report the offending byte and stop
         if (fail) begin
            halted_in          = 1'b1;
            res_valid          = 1'b1;
            res.event_byte     = data_byte;
            res.event_kind     = KIND_ERROR;
            res.first_of_event = 1'b0;
            res.last_of_event  = 1'b1;
            kind_in            = kind_ff;
            rem_in             = rem_ff;
         end

         // event finished: restart with a fresh delta time
         if (done) begin
            phase_in = PH_DELTA;
            delta_in = '0;
            dcnt_in  = '0;
            rem_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DELTA;
         delta_ff  <= '0;
         dcnt_ff   <= '0;
         rem_ff    <= '0;
         kind_ff   <= KIND_NOTE_OFF;
         halted_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         delta_ff  <= delta_in;
         dcnt_ff   <= dcnt_in;
         rem_ff    <= rem_in;
         kind_ff   <= kind_in;
         halted_ff <= halted_in;
      end
   end

   assign status.halted = halted_ff;
   assign status.phase  = phase_ff;

endmodule

// ===== sv/mtep_rsp_stage.sv =====
// ----------------------------------------------------------------------------
// mtep_rsp_stage
// Output register of the result channel; takes a new result whenever it is
// empty or the held one leaves in the same cycle.
// ----------------------------------------------------------------------------
module mtep_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  load_valid,
   input  mtep_pkg::result_type  load_data,
   input  logic                  out_ready,
   output logic                  out_valid,
   output mtep_pkg::result_type  out_data,
   output logic                  in_ready
);
   import mtep_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = load_valid;
         data_in  = load_data;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/midi_track_event_parser_top.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_parser_top
// Takes the body of a MIDI track chunk one byte per request and forwards
// every event byte tagged with its delta time, kind and first/last marks.
// Delta time bytes give no result; an unknown status or meta type, or a
// fifth delta byte, gives one error result and halts the parser until reset.
// One byte is accepted every clock cycle unless the input is stalled; its result,
// if any, appears in the output register on the next cycle. The only thing that
// stalls the input is a full output register that the sink does not take. The
// channel number register is written through the APB port at byte address 0.
// ----------------------------------------------------------------------------
module midi_track_event_parser_top (
   input  logic                               clock,
   input  logic                               reset,
   mtep_req_if.sink                           req_bus,
   mtep_rsp_if.source                         rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mtep_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mtep_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mtep_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import mtep_pkg::*;

   logic              req_accept;
   logic              req_ready;
   logic [CHAN_W-1:0] channel_number;
   logic              res_valid;
   result_type        res;
   result_type        rsp_data;
   status_type        status;

   assign req_accept    = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   mtep_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .channel_number (channel_number)
   );

   mtep_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .data_byte      (req_bus.data_byte),
      .channel_number (channel_number),
      .res_valid      (res_valid),
      .res            (res),
      .status         (status)
   );

   mtep_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .load_valid (res_valid),
      .load_data  (res),
      .out_ready  (rsp_bus.ready),
      .out_valid  (rsp_bus.valid),
      .out_data   (rsp_data),
      .in_ready   (req_ready)
   );

   assign rsp_bus.event_byte     = rsp_data.event_byte;
   assign rsp_bus.delta_time     = rsp_data.delta_time;
   assign rsp_bus.event_kind     = rsp_data.event_kind;
   assign rsp_bus.first_of_event = rsp_data.first_of_event;
   assign rsp_bus.last_of_event  = rsp_data.last_of_event;

   // a halted parser swallows every request
   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      req_accept && status.halted |=> !rsp_bus.valid)
      else $error("result produced while halted");

   // an error result is always the last of its event and halts the parser
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.event_kind == KIND_ERROR
         |-> rsp_bus.last_of_event && !rsp_bus.first_of_event && status.halted)
      else $error("error result without halt or last mark");

   // every byte past the delta time yields a result
   a_event_byte_out: assert property (@(posedge clock) disable iff (reset)
      req_accept && !status.halted && status.phase != PH_DELTA |=> rsp_bus.valid)
      else $error("event byte dropped");

   // a first mark never comes with a last mark
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.first_of_event |-> !rsp_bus.last_of_event)
      else $error("status byte marked as last");

endmodule
